### design/ray_triangle_closest_hit_top_assert.svh
// Assertion macros shared by the checker.
`ifndef RAY_TRIANGLE_CLOSEST_HIT_TOP_ASSERT_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_TOP_ASSERT_SVH

// Same-cycle implication.
`define RTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rtc_pkg.sv
package rtc_pkg;

  localparam int COORD_W   = 32;
  localparam int DIST_W    = 31;
  localparam int VEC_W     = COORD_W + 1;
  localparam int CROSS_W   = 2 * VEC_W + 1;
  localparam int DOT_W     = CROSS_W + VEC_W + 2;
  localparam int QBITS     = COORD_W + 1;
  localparam int IDX_MAX_W = 32;
  localparam int QDEPTH    = 2;
  localparam int CFG_IDX_W = 3;

  localparam int DEF_INDEX_BITS = 24;
  localparam int DEF_FRAC_BITS  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ORG_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd6;

  localparam logic [DIST_W-1:0] LIMIT_RESET = {DIST_W{1'b1}};
  localparam logic [COORD_W-1:0] DIR_Z_RESET = 32'h0001_0000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [VEC_W-1:0]   vec_t;

  // Candidate handed from the front to the back.
  typedef struct packed {
    logic                 first;
    logic                 hit;
    logic [IDX_MAX_W-1:0] idx;
    coord_t               t;
    coord_t               w0;
    coord_t               b1;
    coord_t               b2;
  } cand_t;

endpackage

### design/rtc_front.sv
module rtc_front import rtc_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 item_first,
  input  logic [IDX_MAX_W-1:0] item_idx,
  input  coord_t               v0 [3],
  input  coord_t               v1 [3],
  input  coord_t               v2 [3],
  input  coord_t               org [3],
  input  coord_t               dir [3],
  output logic                 push_valid,
  input  logic                 push_ready,
  output cand_t                push_data
);

  localparam int NW   = DOT_W + FRAC_BITS;
  localparam int DVW  = NW + QBITS;
  localparam int W0_W = COORD_W + 2;
  localparam int LAST_OP = 23;

  typedef enum logic [2:0] {IDLE, MLOAD, MRUN, DLOAD, DRUN, PUSH} state_t;

  state_t state_r;
  logic [4:0] op_r;
  logic [5:0] cnt_r;
  logic [1:0] dv_r;
  logic first_r;
  logic [IDX_MAX_W-1:0] idx_r;
  vec_t e1_r [3];
  vec_t e2_r [3];
  vec_t sv_r [3];
  logic signed [CROSS_W-1:0] s1_r [3];
  logic signed [CROSS_W-1:0] s2_r [3];
  logic signed [DOT_W-1:0] det_r, nt_r, nb1_r, nb2_r;
  logic signed [DOT_W-1:0] acc_r, ma_r;
  logic [VEC_W-1:0] mb_r;
  logic [DVW-1:0] rem_r, dsh_r;
  logic [QBITS-1:0] q_r;
  logic neg_r, ovf_r;
  coord_t t_r, b1_r, b2_r;

  vec_t dv [3];
  logic signed [CROSS_W-1:0] a_sel;
  vec_t b_sel;
  logic sub_sel;
  logic sum_done;
  logic signed [DOT_W-1:0] a_ext, acc_add;
  logic b_neg;

  logic signed [DOT_W-1:0] n_sel;
  logic [DOT_W-1:0] n_mag, d_mag;
  logic [NW-1:0] un, ud;
  logic ge;
  logic [QBITS-1:0] qf, cap, mag;
  coord_t qres;
  logic signed [W0_W-1:0] w0;
  logic signed [W0_W-1:0] one;
  localparam logic signed [W0_W-1:0] W0_MAX = {3'b000, {(COORD_W-1){1'b1}}};

  always_comb begin
    for (int i = 0; i < 3; i++) dv[i] = VEC_W'(dir[i]);
  end

  // Operand schedule: two cross products, then four dot products.
  // sum_done marks the last product of a sum.
  always_comb begin
    a_sel = '0;
    b_sel = '0;
    sub_sel = 1'b0;
    sum_done = 1'b0;
    unique case (op_r)
      5'd0:  begin a_sel = CROSS_W'(dv[1]); b_sel = e2_r[2]; end
      5'd1:  begin
        a_sel = CROSS_W'(dv[2]); b_sel = e2_r[1]; sub_sel = 1'b1; sum_done = 1'b1;
      end
      5'd2:  begin a_sel = CROSS_W'(dv[2]); b_sel = e2_r[0]; end
      5'd3:  begin
        a_sel = CROSS_W'(dv[0]); b_sel = e2_r[2]; sub_sel = 1'b1; sum_done = 1'b1;
      end
      5'd4:  begin a_sel = CROSS_W'(dv[0]); b_sel = e2_r[1]; end
      5'd5:  begin
        a_sel = CROSS_W'(dv[1]); b_sel = e2_r[0]; sub_sel = 1'b1; sum_done = 1'b1;
      end
      5'd6:  begin a_sel = CROSS_W'(sv_r[1]); b_sel = e1_r[2]; end
      5'd7:  begin
        a_sel = CROSS_W'(sv_r[2]); b_sel = e1_r[1]; sub_sel = 1'b1; sum_done = 1'b1;
      end
      5'd8:  begin a_sel = CROSS_W'(sv_r[2]); b_sel = e1_r[0]; end
      5'd9:  begin
        a_sel = CROSS_W'(sv_r[0]); b_sel = e1_r[2]; sub_sel = 1'b1; sum_done = 1'b1;
      end
      5'd10: begin a_sel = CROSS_W'(sv_r[0]); b_sel = e1_r[1]; end
      5'd11: begin
        a_sel = CROSS_W'(sv_r[1]); b_sel = e1_r[0]; sub_sel = 1'b1; sum_done = 1'b1;
      end
      5'd12: begin a_sel = s1_r[0]; b_sel = e1_r[0]; end
      5'd13: begin a_sel = s1_r[1]; b_sel = e1_r[1]; end
      5'd14: begin a_sel = s1_r[2]; b_sel = e1_r[2]; sum_done = 1'b1; end
      5'd15: begin a_sel = s2_r[0]; b_sel = e2_r[0]; end
      5'd16: begin a_sel = s2_r[1]; b_sel = e2_r[1]; end
      5'd17: begin a_sel = s2_r[2]; b_sel = e2_r[2]; sum_done = 1'b1; end
      5'd18: begin a_sel = s1_r[0]; b_sel = sv_r[0]; end
      5'd19: begin a_sel = s1_r[1]; b_sel = sv_r[1]; end
      5'd20: begin a_sel = s1_r[2]; b_sel = sv_r[2]; sum_done = 1'b1; end
      5'd21: begin a_sel = s2_r[0]; b_sel = dv[0]; end
      5'd22: begin a_sel = s2_r[1]; b_sel = dv[1]; end
      5'd23: begin a_sel = s2_r[2]; b_sel = dv[2]; sum_done = 1'b1; end
      default: begin a_sel = '0; b_sel = '0; end
    endcase
    a_ext = DOT_W'(a_sel);
    b_neg = b_sel[VEC_W-1];
    acc_add = mb_r[0] ? acc_r + ma_r : acc_r;
  end

  always_comb begin
    unique case (dv_r)
      2'd0:    n_sel = nt_r;
      2'd1:    n_sel = nb1_r;
      default: n_sel = nb2_r;
    endcase
    n_mag = n_sel[DOT_W-1] ? DOT_W'(-n_sel) : DOT_W'(n_sel);
    d_mag = det_r[DOT_W-1] ? DOT_W'(-det_r) : DOT_W'(det_r);
    un = NW'(n_mag) << FRAC_BITS;
    ud = NW'(d_mag);
    ge = rem_r >= dsh_r;
    qf = {q_r[QBITS-2:0], ge};
    cap = neg_r ? (QBITS'(1) << (COORD_W-1)) : ((QBITS'(1) << (COORD_W-1)) - QBITS'(1));
    mag = (ovf_r || qf > cap) ? cap : qf;
    qres = COORD_W'(neg_r ? -mag : mag);
    one = W0_W'(1) << FRAC_BITS;
    w0 = one - W0_W'(b1_r) - W0_W'(b2_r);
  end

  assign item_stall = (state_r != IDLE);
  assign push_valid = (state_r == PUSH);

  always_comb begin
    push_data.first = first_r;
    push_data.idx = idx_r;
    push_data.hit = (det_r != '0) && (t_r > 0) && (b1_r >= -1) && (b2_r >= -1)
                    && (w0 >= -1);
    push_data.t = t_r;
    push_data.b1 = b1_r;
    push_data.b2 = b2_r;
    push_data.w0 = (w0 > W0_MAX) ? W0_MAX[COORD_W-1:0] : w0[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      op_r <= '0;
      cnt_r <= '0;
      dv_r <= '0;
    end else begin
      unique case (state_r)
        IDLE: begin
          if (item_valid) begin
            first_r <= item_first;
            idx_r <= item_idx;
            for (int i = 0; i < 3; i++) begin
              e1_r[i] <= VEC_W'(v1[i]) - VEC_W'(v0[i]);
              e2_r[i] <= VEC_W'(v2[i]) - VEC_W'(v0[i]);
              sv_r[i] <= VEC_W'(org[i]) - VEC_W'(v0[i]);
            end
            acc_r <= '0;
            op_r <= '0;
            state_r <= MLOAD;
          end
        end
        MLOAD: begin
          ma_r <= (sub_sel ^ b_neg) ? -a_ext : a_ext;
          mb_r <= b_neg ? VEC_W'(-b_sel) : VEC_W'(b_sel);
          cnt_r <= '0;
          state_r <= MRUN;
        end
        MRUN: begin
          acc_r <= (cnt_r == 6'(VEC_W-1) && sum_done) ? '0 : acc_add;
          ma_r <= ma_r <<< 1;
          mb_r <= mb_r >> 1;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(VEC_W-1)) begin
            unique case (op_r)
              5'd1:  s1_r[0] <= CROSS_W'(acc_add);
              5'd3:  s1_r[1] <= CROSS_W'(acc_add);
              5'd5:  s1_r[2] <= CROSS_W'(acc_add);
              5'd7:  s2_r[0] <= CROSS_W'(acc_add);
              5'd9:  s2_r[1] <= CROSS_W'(acc_add);
              5'd11: s2_r[2] <= CROSS_W'(acc_add);
              5'd14: det_r <= acc_add;
              5'd17: nt_r <= acc_add;
              5'd20: nb1_r <= acc_add;
              5'd23: nb2_r <= acc_add;
              default: ;
            endcase
            op_r <= op_r + 5'd1;
            if (op_r == 5'(LAST_OP)) begin
              dv_r <= '0;
              // zero determinant: no division, item goes out as a miss
              state_r <= (det_r == '0) ? PUSH : DLOAD;
            end else begin
              state_r <= MLOAD;
            end
          end
        end
        DLOAD: begin
          neg_r <= n_sel[DOT_W-1] ^ det_r[DOT_W-1];
          ovf_r <= DVW'(un) >= (DVW'(ud) << QBITS);
          rem_r <= DVW'(un);
          dsh_r <= DVW'(ud) << (QBITS-1);
          q_r <= '0;
          cnt_r <= '0;
          state_r <= DRUN;
        end
        DRUN: begin
          if (ge) rem_r <= rem_r - dsh_r;
          dsh_r <= dsh_r >> 1;
          q_r <= qf;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(QBITS-1)) begin
            unique case (dv_r)
              2'd0:    t_r <= qres;
              2'd1:    b1_r <= qres;
              default: b2_r <= qres;
            endcase
            dv_r <= dv_r + 2'd1;
            state_r <= (dv_r == 2'd2) ? PUSH : DLOAD;
          end
        end
        PUSH: begin
          if (push_ready) state_r <= IDLE;
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule

### design/rtc_queue.sv
module rtc_queue import rtc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  cand_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output cand_t pop_data
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cand_t mem [QDEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0] cnt_r;
  logic do_push, do_pop;

  assign push_ready = (cnt_r != (AW+1)'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data = mem[rd_r];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == AW'(QDEPTH-1)) ? '0 : wr_r + AW'(1);
      if (do_pop) rd_r <= (rd_r == AW'(QDEPTH-1)) ? '0 : rd_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

### design/rtc_back.sv
module rtc_back import rtc_pkg::*; #(
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cand_valid,
  output logic                  cand_ready,
  input  cand_t                 cand,
  input  logic [DIST_W-1:0]     limit,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_updated,
  output logic                  out_hit_valid,
  output logic [INDEX_BITS-1:0] out_hit_index,
  output logic [DIST_W-1:0]     out_hit_t,
  output coord_t                out_bary_w0,
  output coord_t                out_bary_w1,
  output coord_t                out_bary_w2
);

  logic valid_r, upd_r, found_r;
  logic [INDEX_BITS-1:0] tri_r;
  logic [DIST_W-1:0] dist_r;
  coord_t w0_r, w1_r, w2_r;

  logic pop, upd;
  logic base_found;
  logic [INDEX_BITS-1:0] base_tri;
  logic [DIST_W-1:0] base_dist;
  coord_t base_w0, base_w1, base_w2;

  assign cand_ready = !valid_r || !out_stall;
  assign pop = cand_valid && cand_ready;

  always_comb begin
    if (cand.first) begin
      base_found = 1'b0;
      base_tri = '0;
      base_dist = limit;
      base_w0 = '0;
      base_w1 = '0;
      base_w2 = '0;
    end else begin
      base_found = found_r;
      base_tri = tri_r;
      base_dist = dist_r;
      base_w0 = w0_r;
      base_w1 = w1_r;
      base_w2 = w2_r;
    end
    // hit implies t > 0, so an unsigned compare is safe
    upd = cand.hit && ($unsigned(cand.t) < {1'b0, base_dist});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      upd_r <= 1'b0;
      found_r <= 1'b0;
      tri_r <= '0;
      dist_r <= LIMIT_RESET;
      w0_r <= '0;
      w1_r <= '0;
      w2_r <= '0;
    end else begin
      if (pop) begin
        valid_r <= 1'b1;
        upd_r <= upd;
        found_r <= upd || base_found;
        tri_r <= upd ? cand.idx[INDEX_BITS-1:0] : base_tri;
        dist_r <= upd ? cand.t[DIST_W-1:0] : base_dist;
        w0_r <= upd ? cand.w0 : base_w0;
        w1_r <= upd ? cand.b1 : base_w1;
        w2_r <= upd ? cand.b2 : base_w2;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_updated = upd_r;
  assign out_hit_valid = found_r;
  assign out_hit_index = tri_r;
  assign out_hit_t = dist_r;
  assign out_bary_w0 = w0_r;
  assign out_bary_w1 = w1_r;
  assign out_bary_w2 = w2_r;

endmodule

### design/ray_triangle_closest_hit_top.sv
// Closest-hit ray/triangle tester, Moller-Trumbore in signed fixed point.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the ray
// origin (0..2), direction (3..5) and distance limit (6); cfg_ready is always
// high, other indexes are dropped. Write only while the block is idle.
// Input channel: one triangle per transfer (three vertices, index, first).
// first restarts the search with the distance limit as best distance.
// Output channel: one record per triangle, the running best hit.
// Each triangle runs 24 products on a bit-serial multiply-accumulate unit,
// then three restoring divisions, a push into the queue and the update of
// the best record; the divisions are skipped when the determinant is zero.
// One triangle is in the math unit at a time, so a new triangle is taken
// only after the last one is pushed; in_stall is high while it works.
// A two-entry queue feeds the compare/update stage, so a stalled receiver
// holds the record in the output register and lets the math unit finish.
// Reset (synchronous, rst_n low) clears the best record and loads register
// defaults: origin 0, direction (0,0,1.0), limit at its maximum.
module ray_triangle_closest_hit_top import rtc_pkg::*; #(
  parameter int INDEX_BITS = DEF_INDEX_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_first,
  input  logic [INDEX_BITS-1:0] in_tri_index,
  input  coord_t                in_v0_x,
  input  coord_t                in_v0_y,
  input  coord_t                in_v0_z,
  input  coord_t                in_v1_x,
  input  coord_t                in_v1_y,
  input  coord_t                in_v1_z,
  input  coord_t                in_v2_x,
  input  coord_t                in_v2_y,
  input  coord_t                in_v2_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_updated,
  output logic                  out_hit_valid,
  output logic [INDEX_BITS-1:0] out_hit_index,
  output logic [DIST_W-1:0]     out_hit_t,
  output coord_t                out_bary_w0,
  output coord_t                out_bary_w1,
  output coord_t                out_bary_w2
);

  coord_t org_r [3];
  coord_t dir_r [3];
  logic [DIST_W-1:0] limit_r;

  coord_t v0 [3];
  coord_t v1 [3];
  coord_t v2 [3];

  logic f_valid, f_ready, q_valid, q_ready;
  cand_t f_data, q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= DIR_Z_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORG_X: org_r[0] <= cfg_data;
        CFG_ORG_Y: org_r[1] <= cfg_data;
        CFG_ORG_Z: org_r[2] <= cfg_data;
        CFG_DIR_X: dir_r[0] <= cfg_data;
        CFG_DIR_Y: dir_r[1] <= cfg_data;
        CFG_DIR_Z: dir_r[2] <= cfg_data;
        CFG_LIMIT: limit_r <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign v0[0] = in_v0_x;
  assign v0[1] = in_v0_y;
  assign v0[2] = in_v0_z;
  assign v1[0] = in_v1_x;
  assign v1[1] = in_v1_y;
  assign v1[2] = in_v1_z;
  assign v2[0] = in_v2_x;
  assign v2[1] = in_v2_y;
  assign v2[2] = in_v2_z;

  rtc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item_stall (in_stall),
    .item_first (in_first),
    .item_idx   (IDX_MAX_W'(in_tri_index)),
    .v0         (v0),
    .v1         (v1),
    .v2         (v2),
    .org        (org_r),
    .dir        (dir_r),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data)
  );

  rtc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  rtc_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cand_valid    (q_valid),
    .cand_ready    (q_ready),
    .cand          (q_data),
    .limit         (limit_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_updated   (out_updated),
    .out_hit_valid (out_hit_valid),
    .out_hit_index (out_hit_index),
    .out_hit_t     (out_hit_t),
    .out_bary_w0   (out_bary_w0),
    .out_bary_w1   (out_bary_w1),
    .out_bary_w2   (out_bary_w2)
  );

endmodule

### design/rtc_checker.sv
`include "ray_triangle_closest_hit_top_assert.svh"

module rtc_checker import rtc_pkg::*; #(
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_updated,
  input logic                  out_hit_valid,
  input logic [INDEX_BITS-1:0] out_hit_index,
  input logic [DIST_W-1:0]     out_hit_t,
  input coord_t                out_bary_w0,
  input coord_t                out_bary_w1,
  input coord_t                out_bary_w2
);

  `RTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hit_t) && $stable(out_hit_index), "stalled result changed")

  `RTC_ASSERT_NOW(a_upd_hit, out_updated, out_hit_valid && (out_hit_t != '0), "update without a recorded hit")

  `RTC_ASSERT_NOW(a_nohit_zero, !out_hit_valid, (out_hit_index == '0) && (out_bary_w0 == '0) && (out_bary_w1 == '0) && (out_bary_w2 == '0), "empty record not cleared")

  `RTC_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "second triangle taken while busy")

endmodule

bind ray_triangle_closest_hit_top rtc_checker #(.INDEX_BITS(INDEX_BITS)) u_rtc_checker (.*);
